[sv/s2cdt_pkg.sv]
package s2cdt_pkg;

    // Field widths
    localparam int SECS_W   = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // Whole days in a 32-bit count fit in 16 bits (at most 49710)
    localparam int DAYS_W    = 16;
    localparam int YOFF_W    = 8;
    localparam int CNT_W     = 4;
    localparam int DIVISOR_W = 17;

    localparam logic [DIVISOR_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [DIVISOR_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [DIVISOR_W-1:0] SECS_PER_MIN  = 17'd60;

    // Reciprocal division: drop the power-of-two factor of the divisor, then
    // multiply by ceil(2^sh / odd part) and keep the bits from sh upwards.
    // Exact because the rounding error times the largest operand stays below 2^sh.
    localparam int PRE_W   = 25;
    localparam int RECIP_W = 26;
    localparam int PROD_W  = PRE_W + RECIP_W;

    localparam int DAY_PRE_SH  = 7;    // 86400 = 675 * 2^7
    localparam int HOUR_PRE_SH = 4;    // 3600  = 225 * 2^4
    localparam int MIN_PRE_SH  = 2;    // 60    = 15  * 2^2

    localparam logic [RECIP_W-1:0] DAY_RECIP  = 26'd50903317;
    localparam logic [RECIP_W-1:0] HOUR_RECIP = 26'd9321;
    localparam logic [RECIP_W-1:0] MIN_RECIP  = 26'd1093;

    localparam int DAY_RECIP_SH  = 35;
    localparam int HOUR_RECIP_SH = 21;
    localparam int MIN_RECIP_SH  = 14;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd2000;
    // 2100 is the only century year in range; 2000 is a 400-year leap year
    localparam logic [YOFF_W-1:0]  CENTURY_OFF = 8'd100;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] DECEMBER    = 4'd11;
    localparam logic [DAYS_W-1:0]  YEAR_DAYS   = 16'd365;
    localparam logic [DAYS_W-1:0]  LEAP_DAYS   = 16'd366;

    // Micro-operations
    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_DIV,
        UOP_YEAR,
        UOP_MONTH,
        UOP_EMIT
    } t_uop;

    // Divisor and destination of a division pass
    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_HOUR,
        DSEL_MIN
    } t_dsel;

    typedef logic [2:0] t_step;

    localparam t_step STEP_WAIT     = 3'd0;
    localparam t_step STEP_DIV_DAY  = 3'd1;
    localparam t_step STEP_DIV_HOUR = 3'd2;
    localparam t_step STEP_DIV_MIN  = 3'd3;
    localparam t_step STEP_YEAR     = 3'd4;
    localparam t_step STEP_MONTH    = 3'd5;
    localparam t_step STEP_EMIT     = 3'd6;

    typedef struct packed {
        t_uop             op;
        t_dsel            dsel;
        logic [CNT_W-1:0] cnt_init;   // loop count loaded on leaving the step
        t_step            next;       // target once the step's condition holds
    } t_uword;

    // Microprogram ROM
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        unique case (pc)
            STEP_WAIT:     w = '{UOP_WAIT,  DSEL_DAY,  4'd1,  STEP_DIV_DAY};
            STEP_DIV_DAY:  w = '{UOP_DIV,   DSEL_DAY,  4'd1,  STEP_DIV_HOUR};
            STEP_DIV_HOUR: w = '{UOP_DIV,   DSEL_HOUR, 4'd1,  STEP_DIV_MIN};
            STEP_DIV_MIN:  w = '{UOP_DIV,   DSEL_MIN,  4'd0,  STEP_YEAR};
            STEP_YEAR:     w = '{UOP_YEAR,  DSEL_DAY,  4'd0,  STEP_MONTH};
            STEP_MONTH:    w = '{UOP_MONTH, DSEL_DAY,  4'd0,  STEP_EMIT};
            STEP_EMIT:     w = '{UOP_EMIT,  DSEL_DAY,  4'd0,  STEP_WAIT};
            default:       w = '{UOP_WAIT,  DSEL_DAY,  4'd1,  STEP_DIV_DAY};
        endcase
        return w;
    endfunction

    // Month length, February extended in leap years
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[sv/seconds_to_calendar_date_time.sv]
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_ready   | i_seconds_since_2000
// result  | out       | o_out_valid / i_out_ready | o_year o_month o_day o_hour o_minute o_second
//
// Each division forms the quotient from the reciprocal product, then the remainder; the year
// walk in the microprogram then goes one year per cycle, followed by the month walk.
// A new input is taken only in the wait step, after the previous result has been emitted.
// Reset returns the sequencer to its wait step and empties the result register.
// A waiting result does not block the next transfer in; only the emit step stalls on it.
module seconds_to_calendar_date_time
    import s2cdt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SECS_W-1:0]   i_seconds_since_2000,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [YEAR_W-1:0]   o_year,
    output logic [MONTH_W-1:0]  o_month,
    output logic [DAY_W-1:0]    o_day,
    output logic [HOUR_W-1:0]   o_hour,
    output logic [MINUTE_W-1:0] o_minute,
    output logic [SECOND_W-1:0] o_second
);

    // Sequencer state
    t_step               r_pc,       n_pc;
    logic [CNT_W-1:0]    r_cnt,      n_cnt;

    // Datapath
    logic [SECS_W-1:0]   r_num,      n_num;      // running remainder of the divisions
    logic [DAYS_W-1:0]   r_quo,      n_quo;      // quotient of the current division
    logic [DAYS_W-1:0]   r_days,     n_days;     // days left to place
    logic [HOUR_W-1:0]   r_hour,     n_hour;
    logic [MINUTE_W-1:0] r_minute,   n_minute;
    logic [YOFF_W-1:0]   r_year_off, n_year_off; // years past the epoch
    logic [MONTH_W-1:0]  r_month,    n_month;    // zero-based

    // Result register
    logic                r_out_valid, n_out_valid;
    logic [YEAR_W-1:0]   r_year_o,   n_year_o;
    logic [MONTH_W-1:0]  r_month_o,  n_month_o;
    logic [DAY_W-1:0]    r_day_o,    n_day_o;
    logic [HOUR_W-1:0]   r_hour_o,   n_hour_o;
    logic [MINUTE_W-1:0] r_minute_o, n_minute_o;
    logic [SECOND_W-1:0] r_second_o, n_second_o;

    t_uword                 w_ctl;
    logic [DIVISOR_W-1:0]   w_divisor;
    logic [PRE_W-1:0]       w_recip_in;
    logic [RECIP_W-1:0]     w_recip_m;
    logic [PROD_W-1:0]      w_recip_prod;
    logic [DAYS_W-1:0]      w_recip_q;
    logic [SECS_W-1:0]      w_back;
    logic [SECS_W-1:0]      w_rem;
    logic                   w_leap;
    logic [DAYS_W-1:0]      w_ylen;
    logic [DAY_W-1:0]       w_mlen;

    assign w_ctl = ucode(r_pc);

    // Shared divider by reciprocal multiplication: the quotient is registered from the
    // product, then the remainder is formed from it
    always_comb begin
        case (w_ctl.dsel)
            DSEL_HOUR: begin
                w_divisor  = SECS_PER_HOUR;
                w_recip_in = r_num[HOUR_PRE_SH +: PRE_W];
                w_recip_m  = HOUR_RECIP;
            end
            DSEL_MIN: begin
                w_divisor  = SECS_PER_MIN;
                w_recip_in = r_num[MIN_PRE_SH +: PRE_W];
                w_recip_m  = MIN_RECIP;
            end
            default: begin
                w_divisor  = SECS_PER_DAY;
                w_recip_in = r_num[DAY_PRE_SH +: PRE_W];
                w_recip_m  = DAY_RECIP;
            end
        endcase
    end

    assign w_recip_prod = PROD_W'(w_recip_in) * PROD_W'(w_recip_m);

    always_comb begin
        case (w_ctl.dsel)
            DSEL_HOUR: w_recip_q = w_recip_prod[HOUR_RECIP_SH +: DAYS_W];
            DSEL_MIN:  w_recip_q = w_recip_prod[MIN_RECIP_SH +: DAYS_W];
            default:   w_recip_q = w_recip_prod[DAY_RECIP_SH +: DAYS_W];
        endcase
    end

    // Quotient times divisor never exceeds the dividend, so 32 bits hold it
    assign w_back = SECS_W'(r_quo) * SECS_W'(w_divisor);
    assign w_rem  = r_num - w_back;

    // Leap test on the year offset; exact over 2000..2199, which covers the range of a 32-bit count
    assign w_leap = (r_year_off[1:0] == 2'b00) && (r_year_off != CENTURY_OFF);
    assign w_ylen = w_leap ? LEAP_DAYS : YEAR_DAYS;
    assign w_mlen = month_len(r_month, w_leap);

    always_comb begin
        n_pc        = r_pc;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_quo       = r_quo;
        n_days      = r_days;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_year_off  = r_year_off;
        n_month     = r_month;
        n_out_valid = r_out_valid;
        n_year_o    = r_year_o;
        n_month_o   = r_month_o;
        n_day_o     = r_day_o;
        n_hour_o    = r_hour_o;
        n_minute_o  = r_minute_o;
        n_second_o  = r_second_o;

        // Drop the result once it has been taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (w_ctl.op)
            UOP_WAIT: begin
                if (i_in_valid) begin
                    n_num      = i_seconds_since_2000;
                    n_cnt      = w_ctl.cnt_init;
                    n_year_off = '0;
                    n_month    = '0;
                    n_pc       = w_ctl.next;
                end
            end
            UOP_DIV: begin
                if (r_cnt != '0) begin
                    // Hold the quotient from the reciprocal product
                    n_quo = w_recip_q;
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    // Keep the remainder and place the quotient
                    n_num = w_rem;
                    n_cnt = w_ctl.cnt_init;
                    n_pc  = w_ctl.next;
                    case (w_ctl.dsel)
                        DSEL_HOUR: n_hour   = r_quo[HOUR_W-1:0];
                        DSEL_MIN:  n_minute = r_quo[MINUTE_W-1:0];
                        default:   n_days   = r_quo;
                    endcase
                end
            end
            UOP_YEAR: begin
                if (r_days < w_ylen) begin
                    n_pc = w_ctl.next;
                end else begin
                    n_days     = r_days - w_ylen;
                    n_year_off = r_year_off + YOFF_W'(1);
                end
            end
            UOP_MONTH: begin
                if ((r_month == DECEMBER) || (r_days < DAYS_W'(w_mlen))) begin
                    n_pc = w_ctl.next;
                end else begin
                    n_days  = r_days - DAYS_W'(w_mlen);
                    n_month = r_month + MONTH_W'(1);
                end
            end
            UOP_EMIT: begin
                // Hold here until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_year_o    = EPOCH_YEAR + YEAR_W'(r_year_off);
                    n_month_o   = r_month + MONTH_W'(1);
                    n_day_o     = r_days[DAY_W-1:0] + DAY_W'(1);
                    n_hour_o    = r_hour;
                    n_minute_o  = r_minute;
                    n_second_o  = r_num[SECOND_W-1:0];
                    n_pc        = w_ctl.next;
                end
            end
            default: begin
                n_pc = STEP_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_WAIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_quo      <= n_quo;
        r_days     <= n_days;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_year_off <= n_year_off;
        r_month    <= n_month;
        r_year_o   <= n_year_o;
        r_month_o  <= n_month_o;
        r_day_o    <= n_day_o;
        r_hour_o   <= n_hour_o;
        r_minute_o <= n_minute_o;
        r_second_o <= n_second_o;
    end

    assign o_in_ready  = (w_ctl.op == UOP_WAIT);
    assign o_out_valid = r_out_valid;
    assign o_year      = r_year_o;
    assign o_month     = r_month_o;
    assign o_day       = r_day_o;
    assign o_hour      = r_hour_o;
    assign o_minute    = r_minute_o;
    assign o_second    = r_second_o;

    // A transfer in starts the day division in its quotient cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_pc == STEP_DIV_DAY && r_cnt == CNT_W'(1)))
        else $error("input transfer did not start the day division");

    // Time of day is fully reduced before the calendar walk
    a_tod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_YEAR) |-> (r_hour < 5'd24 && r_minute < 6'd60 && r_num < 32'd60))
        else $error("time of day out of range after division");

    // The year walk leaves less than one year of days
    a_month_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_MONTH) |-> (r_days < LEAP_DAYS))
        else $error("day count too large for month walk");

    // The emitted day lies inside its month
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_EMIT) |-> (r_month <= DECEMBER && r_days < DAYS_W'(w_mlen)))
        else $error("day outside its month at emit");

endmodule

[tb/seconds_to_calendar_date_time_tb.sv]
module seconds_to_calendar_date_time_tb;
    import s2cdt_pkg::*;

    // Cycles without any transfer on either side before the run is abandoned.
    // The worst honest gap is the long receiver hold-off (HOLD_CYCLES) plus one full
    // conversion plus a burst of idling, so this leaves a wide margin.
    localparam int unsigned STALL_LIMIT  = 4000;
    // Cycles to wait after the last expected result, to catch stray extras
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned HOLD_CYCLES  = 600;

    localparam int unsigned SECS_IN_DAY  = 86400;
    localparam int unsigned SECS_IN_HOUR = 3600;
    localparam int unsigned SECS_IN_MIN  = 60;
    localparam int unsigned FIRST_YEAR   = 2000;
    localparam int unsigned LAST_FULL_YR = 2135;

    // Month lengths in a common year, January first
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    typedef struct {
        logic [SECS_W-1:0]   secs;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_date_time;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [SECS_W-1:0]   in_secs   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;

    // Dates still owed by the block, oldest first
    t_date_time  pending_dates[$];

    int unsigned err_count   = 0;
    int unsigned n_sent      = 0;
    int unsigned n_checked   = 0;
    int unsigned quiet_count = 0;

    // Idling controls shared by the sender task and the receiver process
    bit          src_idle_en = 1'b1;
    bit          snk_idle_en = 1'b1;
    int unsigned hold_req    = 0;
    int unsigned stall_left  = 0;

    string       field_name [6] = '{"year", "month", "day", "hour", "minute", "second"};

    always #2 clk = ~clk;

    seconds_to_calendar_date_time dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_seconds_since_2000 (in_secs),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_year               (year),
        .o_month              (month),
        .o_day                (day),
        .o_hour               (hour),
        .o_minute             (minute),
        .o_second             (second)
    );

    // ------------------------------------------------------------------
    // Calendar arithmetic used for prediction
    // ------------------------------------------------------------------

    // Full Gregorian rule: every 4th year, not every 100th, but every 400th
    function automatic bit leap_year(input int unsigned y);
        if (y % 400 == 0) return 1'b1;
        if (y % 100 == 0) return 1'b0;
        return (y % 4 == 0);
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    // idx counts from 0 for January
    function automatic int unsigned month_days(input int unsigned idx, input bit leap);
        return (idx == 1 && leap) ? 29 : MONTH_DAYS[idx];
    endfunction

    // Expected date and time for a second count: split off the time of day,
    // then walk whole years from 2000 and whole months within the final year.
    function automatic t_date_time calendar_of(input logic [SECS_W-1:0] secs);
        t_date_time  r;
        int unsigned total;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mo;
        bit          leap;
        total = secs;
        days  = total / SECS_IN_DAY;
        tod   = total % SECS_IN_DAY;
        yr    = FIRST_YEAR;
        while (days >= year_days(yr)) begin
            days -= year_days(yr);
            yr++;
        end
        leap = leap_year(yr);
        mo   = 0;
        while (mo < 11 && days >= month_days(mo, leap)) begin
            days -= month_days(mo, leap);
            mo++;
        end
        r.secs   = secs;
        r.year   = yr[YEAR_W-1:0];
        r.month  = MONTH_W'(mo + 1);
        r.day    = DAY_W'(days + 1);
        r.hour   = HOUR_W'(tod / SECS_IN_HOUR);
        r.minute = MINUTE_W'((tod % SECS_IN_HOUR) / SECS_IN_MIN);
        r.second = SECOND_W'(tod % SECS_IN_MIN);
        return r;
    endfunction

    // Second count of a given calendar instant; callers keep it within 32 bits
    function automatic logic [SECS_W-1:0] secs_at(input int unsigned y, input int unsigned mo,
                                                   input int unsigned d, input int unsigned h,
                                                   input int unsigned mi, input int unsigned s);
        longint unsigned days;
        int unsigned     k;
        days = d - 1;
        for (k = FIRST_YEAR; k < y; k++) days += year_days(k);
        for (k = 1; k < mo; k++) days += month_days(k - 1, leap_year(y));
        return SECS_W'(days * SECS_IN_DAY + h * SECS_IN_HOUR + mi * SECS_IN_MIN + s);
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Offer one count and hold it until the transfer. Entered and left on a
    // falling edge so that each edge carries a single update of the valid.
    task automatic send_seconds(input logic [SECS_W-1:0] secs);
        int unsigned gap;
        gap = (src_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_secs  <= secs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_dates.push_back(calendar_of(secs));
        n_sent++;
        @(negedge clk);
    endtask

    // Receiver: decide ready once per falling edge. A requested hold-off takes priority
    // over a new random burst, not over one under way; otherwise accept freely.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left--;
        end else if (hold_req > 0) begin
            out_ready  <= 1'b0;
            stall_left = hold_req - 1;
            hold_req   = 0;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
        end else begin
            out_ready  <= 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Compare one result transfer with the oldest outstanding date
    task automatic check_result();
        t_date_time  want;
        int unsigned got [6];
        int unsigned exp_val [6];
        int          i;
        if (pending_dates.size() == 0) begin
            report_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with nothing outstanding",
                                      year, month, day, hour, minute, second));
            return;
        end
        want = pending_dates.pop_front();
        got[0] = year;   exp_val[0] = want.year;
        got[1] = month;  exp_val[1] = want.month;
        got[2] = day;    exp_val[2] = want.day;
        got[3] = hour;   exp_val[3] = want.hour;
        got[4] = minute; exp_val[4] = want.minute;
        got[5] = second; exp_val[5] = want.second;
        for (i = 0; i < 6; i++) begin
            if (got[i] !== exp_val[i])
                report_mismatch($sformatf("secs 0x%08h: %s is %0d, expected %0d",
                                          want.secs, field_name[i], got[i], exp_val[i]));
        end
        n_checked++;
    endtask

    // Sample the result side on the rising edge, before the block updates
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) check_result();
    end

    // Abandon the run once nothing has moved on either side for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending_dates.size());
                $display("seconds_to_calendar_date_time_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, each time-of-day carry, leap days, year ends and the
    // 2100 century year, which must not get a February 29th
    task automatic test_directed();
        send_seconds(32'h0000_0000);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
        send_seconds(secs_at(2000, 1, 31, 23, 59, 59));
        send_seconds(secs_at(2000, 2, 28, 23, 59, 59));
        send_seconds(secs_at(2000, 2, 29, 12, 0, 0));
        send_seconds(secs_at(2000, 3, 1, 0, 0, 0));
        send_seconds(secs_at(2000, 12, 31, 23, 59, 59));
        send_seconds(secs_at(2001, 1, 1, 0, 0, 0));
        send_seconds(secs_at(2001, 2, 28, 23, 59, 59));
        send_seconds(secs_at(2004, 2, 29, 0, 0, 0));
        send_seconds(secs_at(2099, 12, 31, 23, 59, 59));
        send_seconds(secs_at(2100, 2, 28, 23, 59, 59));
        send_seconds(secs_at(2100, 3, 1, 0, 0, 0));
        send_seconds(secs_at(2104, 2, 29, 6, 30, 30));
        send_seconds(secs_at(2135, 12, 31, 23, 59, 59));
        send_seconds(32'h8000_0000);
        send_seconds(32'h5555_5555);
        send_seconds(32'hAAAA_AAAA);
    endtask

    // Mostly full-range counts; a quarter land on month and year boundaries,
    // and some are small so that the short year walk is exercised often
    task automatic test_random(input int unsigned count);
        int unsigned n;
        int unsigned pick;
        int unsigned y;
        int unsigned mo;
        int unsigned d;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_seconds($urandom);
            end else if (pick < 85) begin
                y  = $urandom_range(FIRST_YEAR, LAST_FULL_YR);
                mo = $urandom_range(1, 12);
                d  = $urandom_range(0, 1) ? 1 : month_days(mo - 1, leap_year(y));
                if ($urandom_range(0, 1))
                    send_seconds(secs_at(y, mo, d, 0, 0, 0));
                else
                    send_seconds(secs_at(y, mo, d, 23, 59, 59));
            end else begin
                send_seconds($urandom_range(0, 32'h0800_0000));
            end
        end
    endtask

    // Hold the result side off for a long stretch while counts keep coming,
    // so that the block fills and drops its input ready
    task automatic test_fill_stall();
        int unsigned n;
        src_idle_en = 1'b0;
        hold_req    = HOLD_CYCLES;
        for (n = 0; n < 12; n++) send_seconds($urandom);
        src_idle_en = 1'b1;
    endtask

    // Final stretch with neither side idling
    task automatic test_back_to_back(input int unsigned count);
        int unsigned n;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        for (n = 0; n < count; n++) send_seconds($urandom);
    endtask

    initial begin
        // Synchronous reset, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(1700);
        test_fill_stall();
        test_back_to_back(300);
        in_valid <= 1'b0;

        // Drain, then watch a little longer for stray results
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d second counts (edges, centuries, random, long stall, no idling);",
                 n_sent);
        $display("%0d results compared, %0d mismatches, %0d left outstanding",
                 n_checked, err_count, pending_dates.size());
        if (err_count == 0 && pending_dates.size() == 0) begin
            $display("seconds_to_calendar_date_time_tb: PASS");
        end else begin
            $display("seconds_to_calendar_date_time_tb: FAIL");
        end
        $finish;
    end

endmodule
